[rtl/lad_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lad_pkg: shared types for the linear array deque
// Operation codes, status codes and the result record passed from the
// sequencer to the output register.
// ----------------------------------------------------------------------------
package lad_pkg;

  // Request operation codes.
  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_REAR  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } op_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // One result item.
  typedef struct packed {
    logic [31:0] pop_value;
    status_e     status;
  } result_t;

endpackage
`default_nettype wire

[rtl/lad_mem.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lad_mem: entry storage for the linear array deque
// One write port and one read port; read data is registered and holds
// until the next read.
// ----------------------------------------------------------------------------
module lad_mem #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  parameter int AW         = $clog2(DEPTH)
) (
  input  wire logic                  clk_i,
  input  wire logic                  we_i,
  input  wire logic [AW-1:0]         waddr_i,
  input  wire logic [DATA_WIDTH-1:0] wdata_i,
  input  wire logic                  re_i,
  input  wire logic [AW-1:0]         raddr_i,
  output logic      [DATA_WIDTH-1:0] rdata_o
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[rtl/lad_seq.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lad_seq: request sequencer for the linear array deque
// Holds the front and rear positions and the empty flag, and drives the
// write and read ports of the memory, with at most one access per cycle;
// the shift is done as a read/write walk from the rear down to slot zero.
// ----------------------------------------------------------------------------
module lad_seq #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  parameter int AW         = $clog2(DEPTH)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire lad_pkg::op_e          op_i,
  input  wire logic [31:0]           value_i,
  input  wire logic                  shift_i,
  input  wire logic                  out_free_i,
  output logic                       res_valid_o,
  output lad_pkg::result_t           res_o,
  output logic                       mem_we_o,
  output logic      [AW-1:0]         mem_waddr_o,
  output logic      [DATA_WIDTH-1:0] mem_wdata_o,
  output logic                       mem_re_o,
  output logic      [AW-1:0]         mem_raddr_o,
  input  wire logic [DATA_WIDTH-1:0] mem_rdata_i
);
  import lad_pkg::*;

  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_POP   = 5'b00010,
    S_SH_RD = 5'b00100,
    S_SH_WR = 5'b01000,
    S_FIN   = 5'b10000
  } state_e;

  state_e                state_q, state_d;
  logic [AW-1:0]         front_q, front_d;
  logic [AW-1:0]         rear_q, rear_d;
  logic                  empty_q, empty_d;
  logic [AW-1:0]         idx_q, idx_d;
  logic [DATA_WIDTH-1:0] val_q, val_d;
  logic                  accept;
  logic [DATA_WIDTH-1:0] in_word;

  assign in_ready_o = (state_q == S_IDLE) && out_free_i;
  assign accept     = in_valid_i && in_ready_o;
  assign in_word    = DATA_WIDTH'(value_i);

  // Next-state and memory port control.
  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    rear_d      = rear_q;
    empty_d     = empty_q;
    idx_d       = idx_q;
    val_d       = val_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = in_word;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;
    res_valid_o = 1'b0;
    res_o       = '{pop_value: '0, status: ST_DONE};

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (op_i)
            OP_PUSH_FRONT: begin
              res_valid_o = 1'b1;
              if (empty_q) begin
                mem_we_o = 1'b1;
                front_d  = '0;
                rear_d   = '0;
                empty_d  = 1'b0;
              end else if (front_q != '0) begin
                mem_we_o    = 1'b1;
                mem_waddr_o = front_q - 1'b1;
                front_d     = front_q - 1'b1;
              end else if (shift_i && (rear_q < LAST)) begin
                // Walk the entries up one slot, starting at the rear.
                res_valid_o = 1'b0;
                idx_d       = rear_q;
                val_d       = in_word;
                state_d     = S_SH_RD;
              end else begin
                res_o.status = ST_FULL;
              end
            end
            OP_PUSH_REAR: begin
              res_valid_o = 1'b1;
              if (empty_q) begin
                mem_we_o = 1'b1;
                front_d  = '0;
                rear_d   = '0;
                empty_d  = 1'b0;
              end else if (rear_q >= LAST) begin
                res_o.status = ST_FULL;
              end else begin
                mem_we_o    = 1'b1;
                mem_waddr_o = rear_q + 1'b1;
                rear_d      = rear_q + 1'b1;
              end
            end
            OP_POP_FRONT, OP_POP_REAR: begin
              if (empty_q) begin
                res_valid_o  = 1'b1;
                res_o.status = ST_EMPTY;
              end else begin
                mem_re_o    = 1'b1;
                mem_raddr_o = (op_i == OP_POP_FRONT) ? front_q : rear_q;
                state_d     = S_POP;
                if (front_q == rear_q) begin
                  front_d = '0;
                  rear_d  = '0;
                  empty_d = 1'b1;
                end else if (op_i == OP_POP_FRONT) begin
                  front_d = front_q + 1'b1;
                end else begin
                  rear_d = rear_q - 1'b1;
                end
              end
            end
          endcase
        end
      end
      S_POP: begin
        if (out_free_i) begin
          res_valid_o     = 1'b1;
          res_o.pop_value = 32'(signed'(mem_rdata_i));
          state_d         = S_IDLE;
        end
      end
      S_SH_RD: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = idx_q;
        state_d     = S_SH_WR;
      end
      S_SH_WR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = idx_q + 1'b1;
        mem_wdata_o = mem_rdata_i;
        if (idx_q == '0) begin
          state_d = S_FIN;
        end else begin
          idx_d   = idx_q - 1'b1;
          state_d = S_SH_RD;
        end
      end
      S_FIN: begin
        if (out_free_i) begin
          mem_we_o    = 1'b1;
          mem_wdata_o = val_q;
          rear_d      = rear_q + 1'b1;
          res_valid_o = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      front_q <= '0;
      rear_q  <= '0;
      empty_q <= 1'b1;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      rear_q  <= rear_d;
      empty_q <= empty_d;
      idx_q   <= idx_d;
    end
  end

  // Held push value for the shift path.
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule
`default_nettype wire

[rtl/linear_array_deque.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// linear_array_deque: double-ended queue in a linear array
// Push and pop at either end of a non-circular array, with an optional
// shift of all entries when pushing at the front of slot zero.
// ----------------------------------------------------------------------------
//  Channel   Dir  Fields (tdata / tuser)
//  s_axis    in   push_value / operation, shift_allowed
//  m_axis    out  pop_value / status
//
// A push without a shift writes its entry when accepted, unless full; a pop
// reads the entry, then gives the result. A push front that shifts does a
// read/write pair for each word moved, from the rear down to slot zero,
// then a final write of the new value to slot zero.
// Reset clears positions and sets the empty flag; entry storage is not cleared.
// A result waits in the output register; the next item is accepted in the
// cycle that result is taken.
// ----------------------------------------------------------------------------
module linear_array_deque #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] push_value
  input  wire logic [2:0]  s_axis_tuser,   // [1:0] operation, [2] shift_allowed
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [31:0] m_axis_tdata,   // [31:0] pop_value
  output logic      [1:0]  m_axis_tuser    // [1:0] status
);
  import lad_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic                  out_valid_q;
  result_t               out_res_q;
  logic                  out_free;
  logic                  res_valid;
  result_t               res;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;

  assign out_free = !out_valid_q || m_axis_tready;

  lad_seq #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .op_i        (op_e'(s_axis_tuser[1:0])),
    .value_i     (s_axis_tdata),
    .shift_i     (s_axis_tuser[2]),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  lad_mem #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_res_q.pop_value;
  assign m_axis_tuser  = out_res_q.status;

  // A new result never overwrites one that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> out_free)
    else $error("result issued while output register is occupied");

  // A rejected request carries a zero pop value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && (res.status != ST_DONE)) |-> (res.pop_value == '0))
    else $error("rejected request with nonzero pop value");

  // An item without an immediate result keeps the block busy next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && !res_valid) |=> !s_axis_tready)
    else $error("multi-cycle item did not hold off the input");

endmodule
`default_nettype wire
